@@ design/vnpr_pkg.sv @@
// vnpr_pkg: shared types and constants for the virtual node partition resolver
// holds payload structs, field widths, status codes and register indexes
// no dependencies
package vnpr_pkg;

    // field widths
    localparam int PARTITION_W = 5;
    localparam int STATUS_W    = 2;
    localparam int HASH_W      = 31;
    localparam int COUNT_W     = 5;
    localparam int LIMIT_W     = 6;
    localparam int HINT_W      = 6;
    localparam int VCOUNT_W    = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    // parameter defaults
    localparam int MAX_PARTITIONS_DEF = 32;
    localparam int VIRTUAL_NODES_DEF  = 1024;

    // operation codes
    localparam logic OP_RESOLVE = 1'b0;
    localparam logic OP_BUILD   = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BUILT  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PARTITION_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODULO_HINT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIRTUAL_COUNT   = 2'd2;

    // register reset values
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 6'd32;
    localparam logic [HINT_W-1:0]   HINT_RST   = 6'd1;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 11'd1024;

    typedef struct packed {
        logic                   operation;
        logic [HASH_W-1:0]      key_hash;
        logic [COUNT_W-1:0]     partition_count;
    } t_vnpr_in;

    typedef struct packed {
        logic [PARTITION_W-1:0] partition;
        logic [STATUS_W-1:0]    status;
    } t_vnpr_out;

endpackage

@@ design/vnpr_ram.sv @@
// vnpr_ram: generic simple dual-port ram, one write and one read port
// read data is registered; no dependencies
module vnpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/virtual_node_partition_resolver.sv @@
// virtual_node_partition_resolver: top level, sequencer, hash divider and node table
// depends on vnpr_pkg and vnpr_ram
//
//   channel   direction  signals                                   payload
//   input     in         i_in_valid / o_in_ready / i_in_data       t_vnpr_in
//   result    out        o_out_valid / i_out_ready / o_out_data    t_vnpr_out
//   config    in         i_cfg_valid / o_cfg_ready / i_cfg_index   i_cfg_data
//
// resolve: the one-bit-per-cycle remainder unit (31 steps) reduces the hash, then the table
//   is read (S_RD, S_RDW); a rejected resolve goes straight to the result
// build: for a limit of 2 or more, each row clears its counters (S_BROW), then each entry
//   reads the previous row (S_BRD) and writes the current row (S_BWR); else no rows are written
// synchronous active-low reset clears control state; the table is not cleared
// input is taken again while a finished result still waits in the output register
// config transactions are taken only while the sequencer is idle
module virtual_node_partition_resolver
    import vnpr_pkg::*;
#(
    parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF,
    parameter int VIRTUAL_NODES  = VIRTUAL_NODES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_vnpr_in               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_vnpr_out              o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int PART_W  = $clog2(MAX_PARTITIONS);
    localparam int ROW_W   = $clog2(MAX_PARTITIONS + 1);
    localparam int NODE_W  = (VIRTUAL_NODES > 1) ? $clog2(VIRTUAL_NODES) : 1;
    localparam int ADDR_W  = PART_W + NODE_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int STEP_W  = $clog2(HASH_W);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_RD   = 8'b0000_0100,
        S_RDW  = 8'b0000_1000,
        S_BROW = 8'b0001_0000,
        S_BRD  = 8'b0010_0000,
        S_BWR  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic                r_built, n_built;
    logic [LIMIT_W-1:0]  r_limit, n_limit;
    logic [HINT_W-1:0]   r_hint, n_hint;
    logic [VCOUNT_W-1:0] r_vcount, n_vcount;
    logic                r_out_valid, n_out_valid;
    t_vnpr_out           r_out, n_out;
    t_vnpr_out           r_result, n_result;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [HASH_W-1:0]   r_hash, n_hash;
    logic [VCOUNT_W-1:0] r_rem, n_rem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [NODE_W-1:0]   r_node, n_node;
    logic [PART_W-1:0]   r_mod, n_mod;
    logic [PART_W-1:0]   r_hits [MAX_PARTITIONS];

    logic [ROW_W-1:0]    eff_limit;
    logic [VCOUNT_W-1:0] eff_virtual;
    logic [VCOUNT_W:0]   trial;
    logic [VCOUNT_W:0]   divisor;
    logic                reject;
    logic                copy_row;
    logic [ROW_W-1:0]    hit_inc;
    logic [PART_W-1:0]   hit_val;
    logic                hit_we;
    logic                hit_clear;
    logic [PART_W-1:0]   copy_val;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [PART_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [PART_W-1:0]   ram_rdata;

    // node table
    vnpr_ram #(
        .WIDTH (PART_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // saturated configuration values
    always_comb begin
        if (32'(r_limit) > MAX_PARTITIONS) begin
            eff_limit = ROW_W'(MAX_PARTITIONS);
        end else begin
            eff_limit = ROW_W'(r_limit);
        end
        if (r_vcount == '0) begin
            eff_virtual = VCOUNT_W'(1);
        end else if (32'(r_vcount) > VIRTUAL_NODES) begin
            eff_virtual = VCOUNT_W'(VIRTUAL_NODES);
        end else begin
            eff_virtual = r_vcount;
        end
    end

    // resolve admission check
    assign reject = !r_built || (i_in_data.partition_count == '0)
                  || (32'(i_in_data.partition_count) >= 32'(eff_limit));

    // remainder step: shift in one hash bit, subtract when it fits
    assign trial   = {r_rem, r_hash[HASH_W-1]};
    assign divisor = {1'b0, eff_virtual};

    // residue counter for the copy rows
    assign copy_row = (r_row != ROW_W'(1)) && (32'(r_row) > 32'(r_hint));
    assign hit_inc  = ROW_W'(r_hits[ram_rdata]) + ROW_W'(1);
    assign hit_val  = (hit_inc >= r_row) ? '0 : PART_W'(hit_inc);
    assign copy_val = (32'(hit_val) + 1 == 32'(r_row)) ? PART_W'(r_row - ROW_W'(1))
                                                       : ram_rdata;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_built     = r_built;
        n_limit     = r_limit;
        n_hint      = r_hint;
        n_vcount    = r_vcount;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_result    = r_result;
        n_count     = r_count;
        n_hash      = r_hash;
        n_rem       = r_rem;
        n_step      = r_step;
        n_row       = r_row;
        n_node      = r_node;
        n_mod       = r_mod;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        hit_we      = 1'b0;
        hit_clear   = 1'b0;

        // result transaction leaves the output register
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.operation == OP_BUILD) begin
                        n_row = ROW_W'(1);
                        if (32'(eff_limit) > 1) begin
                            n_state = S_BROW;
                        end else begin
                            n_built  = 1'b1;
                            n_result = '{partition: '0, status: STATUS_BUILT};
                            n_state  = S_DONE;
                        end
                    end else if (reject) begin
                        n_result = '{partition: '0, status: STATUS_REJECT};
                        n_state  = S_DONE;
                    end else begin
                        n_hash  = i_in_data.key_hash;
                        n_count = i_in_data.partition_count;
                        n_rem   = '0;
                        n_step  = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (trial >= divisor) begin
                    n_rem = VCOUNT_W'(trial - divisor);
                end else begin
                    n_rem = VCOUNT_W'(trial);
                end
                n_hash = r_hash << 1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(HASH_W - 1)) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                ram_re    = 1'b1;
                ram_raddr = {PART_W'(r_count), NODE_W'(r_rem)};
                n_state   = S_RDW;
            end
            S_RDW: begin
                n_result = '{partition: PARTITION_W'(ram_rdata), status: STATUS_OK};
                n_state  = S_DONE;
            end
            S_BROW: begin
                hit_clear = 1'b1;
                n_node    = '0;
                n_mod     = '0;
                n_state   = S_BRD;
            end
            S_BRD: begin
                ram_re    = 1'b1;
                ram_raddr = {PART_W'(r_row - ROW_W'(1)), r_node};
                n_state   = S_BWR;
            end
            S_BWR: begin
                ram_we    = 1'b1;
                ram_waddr = {PART_W'(r_row), r_node};
                if (r_row == ROW_W'(1)) begin
                    ram_wdata = '0;
                end else if (!copy_row) begin
                    ram_wdata = r_mod;
                end else begin
                    ram_wdata = copy_val;
                    hit_we    = 1'b1;
                end
                // running node mod row
                if (32'(r_mod) + 1 == 32'(r_row)) begin
                    n_mod = '0;
                end else begin
                    n_mod = r_mod + PART_W'(1);
                end
                // advance node, then row
                if (32'(r_node) + 1 == 32'(eff_virtual)) begin
                    if (32'(r_row) + 1 == 32'(eff_limit)) begin
                        n_built  = 1'b1;
                        n_result = '{partition: '0, status: STATUS_BUILT};
                        n_state  = S_DONE;
                    end else begin
                        n_row   = r_row + ROW_W'(1);
                        n_state = S_BROW;
                    end
                end else begin
                    n_node  = r_node + NODE_W'(1);
                    n_state = S_BRD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // configuration transaction; any write to a known register invalidates the table
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PARTITION_LIMIT: begin
                    n_limit = i_cfg_data[LIMIT_W-1:0];
                    n_built = 1'b0;
                end
                CFG_MODULO_HINT: begin
                    n_hint  = i_cfg_data[HINT_W-1:0];
                    n_built = 1'b0;
                end
                CFG_VIRTUAL_COUNT: begin
                    n_vcount = i_cfg_data[VCOUNT_W-1:0];
                    n_built  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_built     <= 1'b0;
            r_limit     <= LIMIT_RST;
            r_hint      <= HINT_RST;
            r_vcount    <= VCOUNT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_built     <= n_built;
            r_limit     <= n_limit;
            r_hint      <= n_hint;
            r_vcount    <= n_vcount;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_result <= n_result;
        r_count  <= n_count;
        r_hash   <= n_hash;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_row    <= n_row;
        r_node   <= n_node;
        r_mod    <= n_mod;
    end

    // per-partition residue counters, cleared at each row start
    always_ff @(posedge i_clk) begin
        if (hit_clear) begin
            for (int p = 0; p < MAX_PARTITIONS; p++) begin
                r_hits[p] <= '0;
            end
        end else if (hit_we) begin
            r_hits[ram_rdata] <= hit_val;
        end
    end

    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = i_rst_n && (r_state == S_IDLE);

endmodule

@@ dv/tb_virtual_node_partition_resolver.sv @@
// tb_virtual_node_partition_resolver: self-checking testbench for the partition resolver
// predicts every result from its own copy of the node table and registers
// depends on vnpr_pkg and virtual_node_partition_resolver
module tb_virtual_node_partition_resolver;
    import vnpr_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 3_000_000;
    localparam int unsigned SETTLE_CYCLES   = 40;
    localparam int unsigned END_WAIT_LIMIT  = 200_000;
    localparam int unsigned LONG_HOLD       = 400;
    localparam int unsigned RANDOM_PHASES   = 7;
    localparam int unsigned ITEMS_PER_PHASE = 100;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    // predicted node table, registers and expected result queue
    class placement_checker;
        logic [PARTITION_W-1:0] node_map [MAX_PARTITIONS_DEF][VIRTUAL_NODES_DEF];
        logic [PARTITION_W-1:0] residue [MAX_PARTITIONS_DEF];
        bit                     map_valid;
        logic [LIMIT_W-1:0]     limit_reg;
        logic [HINT_W-1:0]      hint_reg;
        logic [VCOUNT_W-1:0]    vcount_reg;
        t_vnpr_out              expected_results [$];
        int unsigned            mismatches;
        int unsigned            checked;
        int unsigned            resolved;
        int unsigned            rejected;
        int unsigned            rebuilds;

        function new();
            map_valid  = 1'b0;
            limit_reg  = LIMIT_RST;
            hint_reg   = HINT_RST;
            vcount_reg = VCOUNT_RST;
            mismatches = 0;
            checked    = 0;
            resolved   = 0;
            rejected   = 0;
            rebuilds   = 0;
        endfunction

        function int unsigned rows_in_use();
            return (limit_reg > MAX_PARTITIONS_DEF) ? MAX_PARTITIONS_DEF : limit_reg;
        endfunction

        function int unsigned nodes_in_use();
            if (vcount_reg == 0) begin
                return 1;
            end
            return (vcount_reg > VIRTUAL_NODES_DEF) ? VIRTUAL_NODES_DEF : vcount_reg;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // any known register write invalidates the table
        function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            bit known;
            known = 1'b1;
            case (idx)
                CFG_PARTITION_LIMIT: limit_reg = data[LIMIT_W-1:0];
                CFG_MODULO_HINT:     hint_reg = data[HINT_W-1:0];
                CFG_VIRTUAL_COUNT:   vcount_reg = data[VCOUNT_W-1:0];
                default:             known = 1'b0;
            endcase
            if (known) begin
                map_valid = 1'b0;
            end
        endfunction

        // row by row: zeros, plain modulo up to the hint, then residue-driven moves
        function void rebuild_map();
            int unsigned            rows;
            int unsigned            nodes;
            int unsigned            hits;
            logic [PARTITION_W-1:0] prior;
            rows  = rows_in_use();
            nodes = nodes_in_use();
            for (int unsigned r = 1; r < rows; r++) begin
                foreach (residue[k]) begin
                    residue[k] = '0;
                end
                for (int unsigned j = 0; j < nodes; j++) begin
                    if (r == 1) begin
                        node_map[r][j] = '0;
                    end else if (r <= hint_reg) begin
                        node_map[r][j] = PARTITION_W'(j % r);
                    end else begin
                        prior = node_map[r-1][j];
                        hits  = residue[prior] + 1;
                        if (hits >= r) begin
                            hits = 0;
                        end
                        residue[prior] = PARTITION_W'(hits);
                        node_map[r][j] = (hits == r - 1) ? PARTITION_W'(r - 1) : prior;
                    end
                end
            end
            map_valid = 1'b1;
        endfunction

        // work out the result of one accepted request transaction
        function void note_request(t_vnpr_in req);
            t_vnpr_out   want;
            int unsigned node;
            want.partition = '0;
            if (req.operation == OP_BUILD) begin
                rebuild_map();
                want.status = STATUS_BUILT;
                rebuilds++;
            end else if (!map_valid || req.partition_count == 0 ||
                         req.partition_count >= rows_in_use()) begin
                want.status = STATUS_REJECT;
                rejected++;
            end else begin
                node           = req.key_hash % nodes_in_use();
                want.partition = node_map[req.partition_count][node];
                want.status    = STATUS_OK;
                resolved++;
            end
            expected_results.push_back(want);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 40) begin
                $display("mismatch at %0t: %s", $realtime, what);
            end
        endtask

        // compare one result transaction with the oldest expectation
        task check_result(t_vnpr_out got);
            t_vnpr_out want;
            checked++;
            if (expected_results.size() == 0) begin
                report($sformatf("result %0d not expected: partition %0d status %0d",
                                 checked, got.partition, got.status));
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
                report($sformatf("result %0d status %0d, want %0d",
                                 checked, got.status, want.status));
            end
            if (got.partition !== want.partition) begin
                report($sformatf("result %0d partition %0d, want %0d",
                                 checked, got.partition, want.partition));
            end
        endtask

        task close();
            if (expected_results.size() != 0) begin
                report($sformatf("%0d results never arrived", expected_results.size()));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_vnpr_in               i_in_data = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_vnpr_out              o_out_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    placement_checker placement;
    int unsigned      cycle_count = 0;
    int unsigned      burst_left = 0;
    int unsigned      long_holds = 0;
    int unsigned      settings_used = 0;

    virtual_node_partition_resolver DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, placement.pending());
        $display("Regression FAIL");
        $finish;
    end

    // sender: bursts of random length separated by random gaps
    task automatic send_item(t_vnpr_in req);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        placement.note_request(req);
    endtask

    task automatic send_op(logic op, logic [HASH_W-1:0] hash, logic [COUNT_W-1:0] count);
        t_vnpr_in req;
        req.operation       = op;
        req.key_hash        = hash;
        req.partition_count = count;
        send_item(req);
    endtask

    // wait until every expected result is back and the block has settled
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (placement.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // config write; valid stays high for back-to-back writes
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        placement.note_config(idx, data);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] limit_val, logic [CFG_DATA_W-1:0] hint_val,
                             logic [CFG_DATA_W-1:0] vcount_val);
        wait_idle();
        write_reg(CFG_PARTITION_LIMIT, limit_val);
        write_reg(CFG_MODULO_HINT, hint_val);
        write_reg(CFG_VIRTUAL_COUNT, vcount_val);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // mostly resolves on built rows, some bad counts and the odd rebuild
    function automatic t_vnpr_in random_request(bit allow_build);
        t_vnpr_in    req;
        int unsigned rows;
        int unsigned nodes;
        int unsigned pick;
        rows                = placement.rows_in_use();
        nodes               = placement.nodes_in_use();
        req.operation       = OP_RESOLVE;
        req.key_hash        = HASH_W'($urandom);
        req.partition_count = COUNT_W'($urandom);
        pick = $urandom_range(0, 99);
        if (allow_build && pick < 2) begin
            req.operation = OP_BUILD;
        end else if (pick < 82 && rows >= 2) begin
            req.partition_count = COUNT_W'($urandom_range(1, rows - 1));
        end
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            req.key_hash = HASH_W'($urandom_range(0, 2 * nodes));
        end else if (pick < 3) begin
            req.key_hash = 31'h7FFF_FFFF - HASH_W'($urandom_range(0, nodes));
        end
        return req;
    endfunction

    // receiver: ready runs and stalls, plus two long holds to back up the block
    initial begin
        int unsigned ready_left;
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned results_seen;
        ready_left   = 0;
        stall_left   = 0;
        hold_left    = 0;
        results_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                placement.check_result(o_out_data);
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (long_holds < 2 &&
                         results_seen >= ((long_holds == 0) ? 60 : 450)) begin
                hold_left = LONG_HOLD - 1;
                long_holds++;
                i_out_ready <= 1'b0;
            end else if (ready_left > 0) begin
                ready_left--;
                i_out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 20);
                stall_left = $urandom_range(1, 7);
                i_out_ready <= 1'b1;
            end
        end
    end

    // main sequence
    initial begin
        bit          wide;
        int unsigned waited;
        placement = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: unbuilt table, row zero, full build, edge rows and hashes
        send_op(OP_RESOLVE, 31'd0, 5'd5);
        send_op(OP_RESOLVE, 31'h7FFF_FFFF, 5'd0);
        send_op(OP_BUILD, 31'h7FFF_FFFF, 5'd31);
        send_op(OP_RESOLVE, 31'h7FFF_FFFF, 5'd1);
        send_op(OP_RESOLVE, 31'h7FFF_FFFF, 5'd31);
        send_op(OP_RESOLVE, 31'd0, 5'd31);
        send_op(OP_RESOLVE, 31'd1023, 5'd16);
        send_op(OP_RESOLVE, 31'h2AAA_AAAA, 5'd0);

        // write to an unused index keeps the table built
        wait_idle();
        write_reg(CFG_SPARE_INDEX, 11'h5A5);
        i_cfg_valid <= 1'b0;
        send_op(OP_RESOLVE, 31'd12345, 5'd31);

        // oversized limit with upper data bits set, hint of zero
        configure(11'h7E2, 11'd0, 11'd37);
        send_op(OP_RESOLVE, 31'd5, 5'd3);
        send_op(OP_BUILD, 31'd0, 5'd0);
        send_op(OP_RESOLVE, 31'h7FFF_FFFF, 5'd31);
        send_op(OP_RESOLVE, 31'd36, 5'd2);

        // smallest usable limit, zero virtual count
        configure(11'd2, 11'd32, 11'd0);
        send_op(OP_BUILD, 31'h5555_5555, 5'd10);
        send_op(OP_RESOLVE, 31'h7FFF_FFFF, 5'd1);
        send_op(OP_RESOLVE, 31'd9, 5'd2);

        // limits that build no usable row
        configure(11'd1, 11'd5, 11'd3);
        send_op(OP_BUILD, 31'd0, 5'd0);
        send_op(OP_RESOLVE, 31'd2, 5'd1);
        configure(11'd0, 11'd0, 11'd1024);
        send_op(OP_BUILD, 31'd0, 5'd0);
        send_op(OP_RESOLVE, 31'd2, 5'd1);

        // virtual count above range saturates
        configure(11'd20, 11'd8, 11'd2047);
        send_op(OP_BUILD, 31'd77, 5'd3);
        send_op(OP_RESOLVE, 31'h7FFF_FFFF, 5'd19);
        send_op(OP_RESOLVE, 31'd1500, 5'd20);
        send_op(OP_RESOLVE, 31'd7, 5'd8);

        // random settings, small node counts except one wide phase without rebuilds
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            wide = (phase == 3);
            configure(CFG_DATA_W'((phase == 0) ? 32 : $urandom_range(2, 32)),
                      CFG_DATA_W'($urandom_range(0, 32)),
                      CFG_DATA_W'(wide ? $urandom_range(65, 1024) : $urandom_range(1, 64)));
            send_op(OP_BUILD, HASH_W'($urandom), COUNT_W'($urandom));
            repeat (ITEMS_PER_PHASE) send_item(random_request(!wide));
        end

        // drain and settle
        i_in_valid <= 1'b0;
        waited = 0;
        while (placement.pending() != 0 && waited < END_WAIT_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        placement.close();

        $display("run covered %0d resolved keys, %0d rejected requests, %0d table builds",
                 placement.resolved, placement.rejected, placement.rebuilds);
        $display("across %0d register settings with %0d long output holds, %0d mismatches",
                 settings_used, long_holds, placement.mismatches);
        if (placement.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
